// ===== design/fpbp_pkg.sv =====
// Shared types and constants for the fit-policy block placer.
// No dependencies; imported by every module of the block.
package fpbp_pkg;

	localparam int BLOCKS_DEF     = 16;
	localparam int SIZE_BITS_DEF  = 32;
	localparam int BLOCK_INDEX_W  = 4;
	localparam int SPACE_LEFT_W   = 32;
	localparam int COUNT_W        = 5;
	localparam int MODE_W         = 2;
	localparam int CFG_INDEX_W    = 1;
	localparam int CFG_DATA_W     = 5;
	localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(16);

	typedef enum logic [MODE_W-1:0] {
		MODE_FIRST = 2'd0,
		MODE_BEST  = 2'd1,
		MODE_WORST = 2'd2,
		MODE_NEXT  = 2'd3
	} mode_t;

	typedef enum logic {
		CMD_LOAD  = 1'b0,
		CMD_PLACE = 1'b1
	} cmd_code_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_MODE  = 1'b0,
		REG_COUNT = 1'b1
	} reg_index_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;  // latch the command beat, arm the scan
		logic load;     // write a block size, emit result
		logic scan;     // issue one table read
		logic finish;   // commit placement, emit result
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic cnt_zero;
		logic scan_last;
	} dp_status_t;

endpackage

// ===== design/fpbp_ctrl.sv =====
// Sequencing FSM of the fit-policy block placer.
// Depends on fpbp_pkg; drives fpbp_datapath through ctrl_cmd_t.
module fpbp_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic                   command,
	input  fpbp_pkg::dp_status_t   status,
	output logic                   busy,
	output fpbp_pkg::ctrl_cmd_t    cmd
);
	import fpbp_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_LOAD   = 5'b00010,
		S_SCAN   = 5'b00100,
		S_WAIT   = 5'b01000,
		S_UPDATE = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					if (command == CMD_LOAD)
						state_d = S_LOAD;
					else if (status.cnt_zero)
						state_d = S_UPDATE;
					else
						state_d = S_SCAN;
				end
			end
			S_LOAD: begin
				cmd.load = 1'b1;
				state_d  = S_IDLE;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (status.scan_last)
					state_d = S_WAIT;
			end
			S_WAIT: begin
				// last read's compare lands here
				state_d = S_UPDATE;
			end
			S_UPDATE: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	assign busy = (state_q != S_IDLE);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted beat did not raise busy");

endmodule

// ===== design/fpbp_datapath.sv =====
// Space table, scan pointer, fit comparator and result registers.
// Depends on fpbp_pkg; sequenced by fpbp_ctrl.
module fpbp_datapath #(
	parameter int BLOCKS    = fpbp_pkg::BLOCKS_DEF,
	parameter int SIZE_BITS = fpbp_pkg::SIZE_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  fpbp_pkg::ctrl_cmd_t                  cmd,
	output fpbp_pkg::dp_status_t                 status,
	input  logic [fpbp_pkg::BLOCK_INDEX_W-1:0]   block_index,
	input  logic [SIZE_BITS-1:0]                 size,
	input  fpbp_pkg::mode_t                      mode,
	input  logic [fpbp_pkg::COUNT_W-1:0]         count,
	output logic                                 done,
	output logic                                 placed,
	output logic [fpbp_pkg::BLOCK_INDEX_W-1:0]   chosen_block,
	output logic [fpbp_pkg::SPACE_LEFT_W-1:0]    space_left
);
	import fpbp_pkg::*;

	localparam int IDX_W = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
	localparam int CNT_W = $clog2(BLOCKS + 1);

	logic [SIZE_BITS-1:0]     mem [BLOCKS];

	logic [BLOCK_INDEX_W-1:0] idx_q;
	logic [SIZE_BITS-1:0]     size_q;
	logic [IDX_W-1:0]         rover_q;
	logic [IDX_W-1:0]         pos_q;
	logic [CNT_W-1:0]         j_q;
	logic                     found_q;
	logic [IDX_W-1:0]         pick_q;
	logic [SIZE_BITS-1:0]     best_q;
	logic                     done_q;

	logic                     valid_s1;
	logic [IDX_W-1:0]         idx_s1;
	logic [SIZE_BITS-1:0]     rd_data_s1;

	logic [CNT_W-1:0]         cnt;
	logic [IDX_W-1:0]         start_pos;
	logic [IDX_W-1:0]         next_pos;
	logic                     in_table;
	logic                     fits;
	logic                     take;
	logic [SIZE_BITS-1:0]     new_space;
	logic                     wr_en;
	logic [IDX_W-1:0]         wr_addr;
	logic [SIZE_BITS-1:0]     wr_data;

	// effective block count, clipped to the table
	assign cnt = (32'(count) > 32'(BLOCKS)) ? CNT_W'(BLOCKS) : CNT_W'(count);

	assign status.cnt_zero  = (count == '0);
	assign status.scan_last = (32'(j_q) + 32'd1 == 32'(cnt));

	assign start_pos = ((mode == MODE_NEXT) && (32'(rover_q) < 32'(cnt))) ? rover_q : '0;
	assign next_pos  = (32'(pos_q) + 32'd1 >= 32'(cnt)) ? '0 : pos_q + 1'b1;

	assign in_table  = (32'(idx_q) < 32'(BLOCKS));

	// fit test and policy compare on the returning read
	assign fits = (rd_data_s1 >= size_q);
	assign take = fits && (!found_q
		|| ((mode == MODE_BEST)  && (rd_data_s1 < best_q))
		|| ((mode == MODE_WORST) && (rd_data_s1 > best_q)));

	assign new_space = best_q - size_q;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = pick_q;
		wr_data = new_space;
		if (cmd.load) begin
			wr_en   = in_table;
			wr_addr = IDX_W'(idx_q);
			wr_data = size_q;
		end else if (cmd.finish) begin
			wr_en   = found_q;
		end
	end

	// space table: one write, one registered read
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (cmd.scan)
			rd_data_s1 <= mem[pos_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			idx_q  <= block_index;
			size_q <= size;
		end
		if (cmd.scan)
			idx_s1 <= pos_q;
		if (valid_s1 && take) begin
			pick_q <= idx_s1;
			best_q <= rd_data_s1;
		end
		if (cmd.load) begin
			placed       <= 1'b0;
			chosen_block <= idx_q;
			space_left   <= in_table ? SPACE_LEFT_W'(size_q) : '0;
		end else if (cmd.finish) begin
			placed       <= found_q;
			chosen_block <= found_q ? BLOCK_INDEX_W'(pick_q) : '0;
			space_left   <= found_q ? SPACE_LEFT_W'(new_space) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rover_q  <= '0;
			pos_q    <= '0;
			j_q      <= '0;
			found_q  <= 1'b0;
			valid_s1 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= cmd.scan;
			done_q   <= cmd.load || cmd.finish;
			if (cmd.capture) begin
				pos_q   <= start_pos;
				j_q     <= '0;
				found_q <= 1'b0;
			end else if (cmd.scan) begin
				pos_q <= next_pos;
				j_q   <= j_q + 1'b1;
			end
			if (valid_s1 && fits)
				found_q <= 1'b1;
			if (cmd.load)
				rover_q <= '0;
			else if (cmd.finish && found_q && (mode == MODE_NEXT))
				rover_q <= pick_q;
		end
	end

	assign done = done_q;

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load || cmd.finish) |=> done)
		else $error("result strobe missing");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan |-> (32'(j_q) < 32'(cnt)))
		else $error("scan ran past block count");

	a_rover_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(rover_q) < 32'(BLOCKS))
		else $error("rover outside table");

endmodule

// ===== design/fit_policy_block_placer.sv =====
// Top level of the fit-policy block placer: config registers, FSM, datapath.
// Depends on fpbp_pkg, fpbp_ctrl and fpbp_datapath.
//
//  channel   | handshake              | beat contents
//  ----------+------------------------+-----------------------------------
//  command   | start / busy           | command, block_index, size
//  result    | done (strobe, 1 cycle) | placed, chosen_block, space_left
//  config    | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A load beat passes through S_LOAD and back to idle; its result strobes in
// the cycle that busy falls. A place beat makes one table read per block in
// use (at most BLOCKS) through the single read port, then a state for the last
// compare and one to write back; with no block in use it skips to the write-back.
// Reset: mode first fit, count 16, rover 0; table contents unknown until loaded.
// The result is presented once and cannot be held off; the next command may be
// accepted in the same cycle as the strobe.
module fit_policy_block_placer #(
	parameter int BLOCKS    = fpbp_pkg::BLOCKS_DEF,
	parameter int SIZE_BITS = fpbp_pkg::SIZE_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// command beat
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 command,
	input  logic [fpbp_pkg::BLOCK_INDEX_W-1:0]   block_index,
	input  logic [SIZE_BITS-1:0]                 size,
	// result beat
	output logic                                 done,
	output logic                                 placed,
	output logic [fpbp_pkg::BLOCK_INDEX_W-1:0]   chosen_block,
	output logic [fpbp_pkg::SPACE_LEFT_W-1:0]    space_left,
	// config write
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [fpbp_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [fpbp_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import fpbp_pkg::*;

	mode_t              mode_q;
	logic [COUNT_W-1:0] count_q;
	ctrl_cmd_t          cmd;
	dp_status_t         status;

	// config is always writable; it is to be written only while idle, which the block does not enforce
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_FIRST;
			count_q <= COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_index_t'(cfg_index))
				REG_MODE:  mode_q  <= mode_t'(cfg_data[MODE_W-1:0]);
				REG_COUNT: count_q <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	fpbp_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (command),
		.status  (status),
		.busy    (busy),
		.cmd     (cmd)
	);

	fpbp_datapath #(
		.BLOCKS    (BLOCKS),
		.SIZE_BITS (SIZE_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.block_index  (block_index),
		.size         (size),
		.mode         (mode_q),
		.count        (count_q),
		.done         (done),
		.placed       (placed),
		.chosen_block (chosen_block),
		.space_left   (space_left)
	);

endmodule

// ===== tb/fpbp_tb_pkg.sv =====
// Scoreboard for the fit-policy block placer bench: keeps its own copy of the
// space table, rover and registers, and checks result beats in order.
// Depends on fpbp_pkg.
package fpbp_tb_pkg;
	import fpbp_pkg::*;

	typedef struct packed {
		logic                     placed;
		logic [BLOCK_INDEX_W-1:0] blk;
		logic [SPACE_LEFT_W-1:0]  left;
	} outcome_t;

	class placement_scoreboard;
		logic [SIZE_BITS_DEF-1:0] free_space [BLOCKS_DEF];
		logic [BLOCK_INDEX_W-1:0] rover;
		mode_t                    policy;
		logic [COUNT_W-1:0]       blocks_in_use;
		outcome_t                 pending_outcomes [$];
		int errors, loads, places, hits, misses, settings;

		function new();
			foreach (free_space[i]) free_space[i] = '0;
			rover = '0;
			policy = MODE_FIRST;
			blocks_in_use = COUNT_RESET;
			errors = 0; loads = 0; places = 0; hits = 0; misses = 0; settings = 0;
		endfunction

		function void write_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_MODE: begin
					policy = mode_t'(data[MODE_W-1:0]);
				end
				REG_COUNT: begin
					blocks_in_use = data[COUNT_W-1:0];
				end
			endcase
			settings++;
		endfunction

		// works out the result beat of one command and updates the table
		function outcome_t place_outcome(cmd_code_t cmd, logic [BLOCK_INDEX_W-1:0] idx,
				logic [SIZE_BITS_DEF-1:0] sz);
			outcome_t res;
			int span, pos, pick;
			bit found;
			res = '0;
			span = (blocks_in_use > BLOCKS_DEF) ? BLOCKS_DEF : int'(blocks_in_use);
			if (cmd == CMD_LOAD) begin
				rover = '0;
				free_space[idx] = sz;
				res.blk = idx;
				res.left = sz;
				loads++;
				return res;
			end
			places++;
			found = 0;
			pick = 0;
			if (policy == MODE_NEXT) begin
				// circular scan from the rover, back to 0 if the rover is out of range
				pos = (rover < span) ? int'(rover) : 0;
				for (int j = 0; j < span; j++) begin
					if (free_space[pos] >= sz) begin
						pick = pos;
						found = 1;
						break;
					end
					pos = (pos + 1 >= span) ? 0 : pos + 1;
				end
				if (found) rover = BLOCK_INDEX_W'(pick);
			end else begin
				for (int j = 0; j < span; j++) begin
					if (free_space[j] < sz) continue;
					if (!found) begin
						pick = j;
						found = 1;
						if (policy == MODE_FIRST) break;
					end else if (policy == MODE_BEST && free_space[j] < free_space[pick]) begin
						pick = j;
					end else if (policy == MODE_WORST && free_space[j] > free_space[pick]) begin
						pick = j;
					end
				end
			end
			if (!found) begin
				misses++;
				return res;
			end
			hits++;
			free_space[pick] = free_space[pick] - sz;
			res.placed = 1'b1;
			res.blk = BLOCK_INDEX_W'(pick);
			res.left = free_space[pick];
			return res;
		endfunction

		function void note_command(cmd_code_t cmd, logic [BLOCK_INDEX_W-1:0] idx,
				logic [SIZE_BITS_DEF-1:0] sz);
			pending_outcomes.push_back(place_outcome(cmd, idx, sz));
		endfunction

		function void check_result(logic placed, logic [BLOCK_INDEX_W-1:0] blk,
				logic [SPACE_LEFT_W-1:0] left);
			outcome_t want;
			if (pending_outcomes.size() == 0) begin
				$display("%0t: unexpected result beat: placed %0b block %0d space %0d",
					$time, placed, blk, left);
				errors++;
				return;
			end
			want = pending_outcomes.pop_front();
			if (placed !== want.placed) begin
				$display("%0t: placed mismatch: expected %0b, got %0b", $time, want.placed, placed);
				errors++;
			end
			if (blk !== want.blk) begin
				$display("%0t: chosen_block mismatch: expected %0d, got %0d", $time, want.blk, blk);
				errors++;
			end
			if (left !== want.left) begin
				$display("%0t: space_left mismatch: expected %0d, got %0d", $time, want.left, left);
				errors++;
			end
		endfunction
	endclass

endpackage

// ===== tb/tb_top.sv =====
// Top-level bench for fit_policy_block_placer: directed and random command beats
// under all four policies and a range of block counts, checked by the scoreboard.
// Depends on fpbp_pkg, fpbp_tb_pkg and the placer RTL.
module tb_top;
	import fpbp_pkg::*;
	import fpbp_tb_pkg::*;

	// worst item: a 16-block scan plus overhead plus a sender gap;
	// ~1300 items plus drains fit well inside this
	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = BLOCKS_DEF + 8;
	localparam int PHASES        = 12;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic                     command = 1'b0;
	logic [BLOCK_INDEX_W-1:0] block_index = '0;
	logic [SIZE_BITS_DEF-1:0] size = '0;
	logic                     cfg_valid = 1'b0;
	logic [CFG_INDEX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]    cfg_data = '0;
	logic                     busy, done, placed, cfg_ready;
	logic [BLOCK_INDEX_W-1:0] chosen_block;
	logic [SPACE_LEFT_W-1:0]  space_left;

	placement_scoreboard sb;
	int sender_idle_pct = 0;

	// block counts per random phase: reset value, 1, zero, above the table, odd sizes
	int phase_counts [PHASES] = '{16, 1, 31, 0, 5, 17, 3, 16, 2, 8, 16, 12};
	int idle_plan [3] = '{0, 59, 19};

	always #5 clk = ~clk;

	fit_policy_block_placer i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.block_index  (block_index),
		.size         (size),
		.done         (done),
		.placed       (placed),
		.chosen_block (chosen_block),
		.space_left   (space_left),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// result beats last one cycle and cannot be held off: sample every edge
	always @(posedge clk) begin
		if (arst_n && done) sb.check_result(placed, chosen_block, space_left);
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("%0t: timeout, %0d results still pending", $time, sb.pending_outcomes.size());
		$display("tb_top: FAIL");
		$finish;
	end

	// Present one command beat and hold it until the block takes it. start is
	// left high so a back-to-back beat needs no second assignment in this step.
	task automatic send_beat(cmd_code_t cmd, logic [BLOCK_INDEX_W-1:0] idx,
			logic [SIZE_BITS_DEF-1:0] sz);
		start <= 1'b1;
		command <= cmd;
		block_index <= idx;
		size <= sz;
		do @(posedge clk); while (busy);
		sb.note_command(cmd, idx, sz);
	endtask

	// optional sender gap with junk on the fields, then the beat
	task automatic issue(cmd_code_t cmd, logic [BLOCK_INDEX_W-1:0] idx,
			logic [SIZE_BITS_DEF-1:0] sz);
		int gap;
		if ($urandom_range(0, 99) < sender_idle_pct) begin
			gap = $urandom_range(1, 4);
			start <= 1'b0;
			command <= 1'($urandom);
			block_index <= BLOCK_INDEX_W'($urandom);
			size <= $urandom;
			repeat (gap) @(posedge clk);
		end
		send_beat(cmd, idx, sz);
	endtask

	// sender holds off until every outstanding result has come back
	task automatic drain();
		start <= 1'b0;
		while (sb.pending_outcomes.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// one register beat; cfg_valid is lowered by the caller once all are sent
	task automatic put_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
	endtask

	// registers only change with the block idle; upper bits of the mode beat are junk
	task automatic configure(mode_t m, logic [CFG_DATA_W-1:0] count);
		drain();
		put_reg(REG_MODE, {3'($urandom), m});
		put_reg(REG_COUNT, count);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// mostly small sizes so blocks fill up and run out; extremes now and then
	function automatic logic [SIZE_BITS_DEF-1:0] pick_size(bit for_load);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 10) return '0;
		if (roll < (for_load ? 20 : 15)) return '1;
		if (roll < 70) return for_load ? $urandom_range(1, 64) : $urandom_range(0, 16);
		return $urandom;
	endfunction

	initial begin
		int span, n_items;
		logic [BLOCK_INDEX_W-1:0] idx;
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: four blocks with the size extremes, then each policy in turn.
		configure(MODE_FIRST, 4);
		issue(CMD_LOAD, 0, 10);
		issue(CMD_LOAD, 1, '1);
		issue(CMD_LOAD, 2, 5);
		issue(CMD_LOAD, 3, '0);
		issue(CMD_PLACE, 4'hF, '0);   // zero request lands on block 0 unchanged
		issue(CMD_PLACE, 0, '1);      // full-width request empties block 1
		issue(CMD_PLACE, 0, 11);      // nothing large enough
		configure(MODE_BEST, 4);
		issue(CMD_PLACE, 0, 4);
		configure(MODE_WORST, 4);
		issue(CMD_PLACE, 0, 3);
		configure(MODE_NEXT, 4);
		issue(CMD_PLACE, 0, 1);
		issue(CMD_PLACE, 0, 7);       // no fit, rover must stay put
		issue(CMD_PLACE, 0, 2);
		issue(CMD_LOAD, 3, 8);        // load sends the rover home
		issue(CMD_PLACE, 0, 6);       // rover moves to block 3
		configure(MODE_NEXT, 2);      // rover now past the count: scan from 0
		issue(CMD_PLACE, 0, 1);
		issue(CMD_LOAD, 9, 77);       // stored though outside the count
		configure(MODE_FIRST, 0);     // no block in use at all
		issue(CMD_PLACE, 0, 5);
		issue(CMD_PLACE, 0, '0);

		// Load every block so that any count reads only written entries.
		configure(MODE_FIRST, 16);
		for (int i = 0; i < BLOCKS_DEF; i++) issue(CMD_LOAD, BLOCK_INDEX_W'(i), pick_size(1'b1));

		// Random phases: every policy against every sender idling level.
		for (int p = 0; p < PHASES; p++) begin
			configure(mode_t'(2'(p)), CFG_DATA_W'(phase_counts[p]));
			sender_idle_pct = idle_plan[p % 3];
			span = (phase_counts[p] > BLOCKS_DEF) ? BLOCKS_DEF : phase_counts[p];
			n_items = (span == 0) ? 30 : 112;
			for (int k = 0; k < n_items; k++) begin
				if ($urandom_range(0, 63) == 0) drain();
				if ($urandom_range(0, 99) < 25) begin
					// loads mostly refresh blocks in use, sometimes those beyond
					if (span > 0 && $urandom_range(0, 3) != 0) begin
						idx = BLOCK_INDEX_W'($urandom_range(0, span - 1));
					end else begin
						idx = BLOCK_INDEX_W'($urandom_range(0, BLOCKS_DEF - 1));
					end
					issue(CMD_LOAD, idx, pick_size(1'b1));
				end else begin
					issue(CMD_PLACE, BLOCK_INDEX_W'($urandom), pick_size(1'b0));
				end
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Run covered %0d loads and %0d placements (%0d placed, %0d no fit)",
			sb.loads, sb.places, sb.hits, sb.misses);
		$display("over %0d register writes: all policies, counts 0..31, sender idle 0/19/59%%",
			sb.settings);
		if (sb.errors == 0 && sb.pending_outcomes.size() == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
design/fpbp_pkg.sv
design/fpbp_ctrl.sv
design/fpbp_datapath.sv
design/fit_policy_block_placer.sv
tb/fpbp_tb_pkg.sv
tb/tb_top.sv
